>>> rtl/kbce_pkg.sv
package kbce_pkg;

   localparam int KEY_BYTES   = 32;
   localparam int CHUNK_W     = 28;
   localparam int GROUP_W     = 5;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'h0000;
   localparam logic [7:0]  VERSION_RESET = 8'(6 << 3);

   // One input byte's worth of characters, left-aligned, waiting to be sent.
   typedef struct packed {
      logic [CHUNK_W-1:0] bits;
      logic [2:0]         count;
      logic               last;
   } kbce_word_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic [6:0] b32_char(input logic [4:0] v);
      if (v < 5'd26) begin
         return 7'd65 + {2'b00, v};
      end else begin
         return 7'd24 + {2'b00, v};
      end
   endfunction

   // Number of whole 5-bit groups in a stream of up to 28 bits.
   function automatic logic [2:0] group_count(input logic [4:0] bits);
      if (bits >= 5'd25) begin
         return 3'd5;
      end else if (bits >= 5'd20) begin
         return 3'd4;
      end else if (bits >= 5'd15) begin
         return 3'd3;
      end else if (bits >= 5'd10) begin
         return 3'd2;
      end else if (bits >= 5'd5) begin
         return 3'd1;
      end else begin
         return 3'd0;
      end
   endfunction

endpackage

>>> rtl/kbce_pack.sv
module kbce_pack
   import kbce_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [7:0]    req_tdata,
   input  logic          csr_wr_en,
   input  logic [7:0]    csr_wr_data,
   output kbce_word_type word
);

   logic [7:0]  version_ff, version_in;
   logic [4:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [3:0]  lo_ff, lo_in;
   logic [2:0]  bc_ff, bc_in;

   logic        first, last, fire;
   logic [15:0] crc_key;
   logic [23:0] nb_al;
   logic [4:0]  nbits, total, shift;
   logic [2:0]  nchars;
   logic [CHUNK_W-1:0] combined, shifted;

   always_comb begin
      fire  = req_tvalid && req_tready;
      first = (count_ff == 5'd0);
      last  = (count_ff == 5'(KEY_BYTES - 1));

      if (first) begin
         crc_key = crc_byte(crc_byte(CRC_INIT, version_ff), req_tdata);
      end else begin
         crc_key = crc_byte(crc_ff, req_tdata);
      end

      if (first) begin
         nb_al = {version_ff, req_tdata, 8'h00};
         nbits = 5'd16;
      end else if (last) begin
         // Checksum goes out low byte first right behind the final key byte.
         nb_al = {req_tdata, crc_key[7:0], crc_key[15:8]};
         nbits = 5'd24;
      end else begin
         nb_al = {req_tdata, 16'h0000};
         nbits = 5'd8;
      end

      // Leftover bits are kept left-aligned, so the new bits slide in below them.
      combined = {lo_ff, 24'h000000} | ({nb_al, 4'h0} >> bc_ff);
      total    = 5'({2'b00, bc_ff}) + nbits;
      nchars   = group_count(total);
      shift    = 5'({2'b00, nchars} << 2) + 5'({2'b00, nchars});
      shifted  = combined << shift;

      word.bits  = combined;
      word.count = nchars;
      word.last  = last;

      version_in = csr_wr_en ? csr_wr_data : version_ff;
      count_in   = count_ff;
      crc_in     = crc_ff;
      lo_in      = lo_ff;
      bc_in      = bc_ff;
      if (fire) begin
         if (last) begin
            count_in = 5'd0;
            crc_in   = CRC_INIT;
            lo_in    = 4'h0;
            bc_in    = 3'd0;
         end else begin
            count_in = count_ff + 5'd1;
            crc_in   = crc_key;
            lo_in    = shifted[CHUNK_W-1 -: 4];
            bc_in    = 3'(total - shift);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= VERSION_RESET;
         count_ff   <= 5'd0;
         crc_ff     <= CRC_INIT;
         lo_ff      <= 4'h0;
         bc_ff      <= 3'd0;
      end else begin
         version_ff <= version_in;
         count_ff   <= count_in;
         crc_ff     <= crc_in;
         lo_ff      <= lo_in;
         bc_ff      <= bc_in;
      end
   end

endmodule

>>> rtl/kbce_emit.sv
module kbce_emit
   import kbce_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          word_valid,
   input  kbce_word_type word,
   output logic          word_ready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [6:0]    rsp_char,
   output logic          rsp_tlast
);

   logic [CHUNK_W-1:0] bits_ff, bits_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic               last_ff, last_in;
   logic               valid_ff, valid_in;
   logic [6:0]         char_ff, char_in;
   logic               tlast_ff, tlast_in;
   logic               take, load;

   always_comb begin
      take       = (cnt_ff != 3'd0) && (!valid_ff || rsp_tready);
      word_ready = (cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && take);
      load       = word_valid && word_ready;

      bits_in = bits_ff;
      cnt_in  = cnt_ff;
      last_in = last_ff;
      if (load) begin
         bits_in = word.bits;
         cnt_in  = word.count;
         last_in = word.last;
      end else if (take) begin
         bits_in = bits_ff << GROUP_W;
         cnt_in  = cnt_ff - 3'd1;
      end

      valid_in = valid_ff;
      char_in  = char_ff;
      tlast_in = tlast_ff;
      if (take) begin
         valid_in = 1'b1;
         char_in  = b32_char(bits_ff[CHUNK_W-1 -: GROUP_W]);
         tlast_in = last_ff && (cnt_ff == 3'd1);
      end else if (rsp_tready) begin
         valid_in = 1'b0;
         tlast_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= 3'd0;
         last_ff  <= 1'b0;
         valid_ff <= 1'b0;
         tlast_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
         valid_ff <= valid_in;
         tlast_ff <= tlast_in;
      end
      bits_ff <= bits_in;
      char_ff <= char_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_char   = char_ff;
   assign rsp_tlast  = tlast_ff;

`ifndef ASSERT_OFF
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd5) else $error("character count out of range");
   a_load_count: assert property (@(posedge clock) disable iff (reset)
      load |-> (word.count != 3'd0) && (word.count <= 3'd5))
      else $error("loaded word carries no valid character count");
   a_tlast_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tlast |-> rsp_tvalid) else $error("tlast without a valid word");
   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_tvalid) else $error("character taken but not presented");
`endif

endmodule

>>> rtl/key_base32_checksum_encoder.sv
// An accepted key byte is loaded into the emitter's shift register; its characters then leave
// one at a time through the registered output. One character per cycle on the result side while
// rsp_tready is high and key bytes keep coming; a key byte makes 1 or 2 characters for most,
// 3 for the first, 5 for the last. The emitter takes the next byte as its last character is registered.
// Reset is synchronous and active high; it clears the address state and sets the version to 48.
module key_base32_checksum_encoder
   import kbce_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] key_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] text_char, [7] zero
   output logic       rsp_tlast,   // last_char
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data  // version_byte
);

   kbce_word_type word;
   logic          word_ready;
   logic [6:0]    rsp_char;

   assign req_tready = word_ready;

   kbce_pack u_pack (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (word_ready),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .word        (word)
   );

   kbce_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .word_valid (req_tvalid),
      .word       (word),
      .word_ready (word_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_char   (rsp_char),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, rsp_char};

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import kbce_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_ITEMS  = 200;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic [6:0] text_char;
      logic       last_char;
   } text_char_type;

   typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_TOGGLE, RX_SPARSE} rx_mode_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_tvalid  = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata   = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready  = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       csr_wr_en   = 1'b0;
   logic [7:0] csr_wr_data = 8'h00;

   // Key bytes waiting for the driver, and characters the encoder still owes us.
   logic [7:0] key_byte_q[$];
   text_char_type text_char_q[$];

   // Shadow of the encoder's address state.
   logic [7:0]  shadow_version;
   int          shadow_count;
   logic [15:0] shadow_crc;
   logic [27:0] shadow_bits;
   int          shadow_nbits;

   int          err_count    = 0;
   int          cycle_count  = 0;
   int          items_pushed = 0;
   int          items_taken  = 0;
   logic        req_taken    = 1'b0;
   int          gap_left     = 0;
   int          burst_left   = 0;
   int          hold_req     = 0;
   int          hold_seen    = 0;
   int          hold_left    = 0;
   int          mode_left    = 0;
   rx_mode_type stall_mode   = RX_OPEN;

   always #HALF_PERIOD clock = ~clock;

   key_base32_checksum_encoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb  = crc[15] ^ b[i];
         crc = {crc[14:0], 1'b0};
         if (fb) begin
            crc = crc ^ CRC_POLY;
         end
      end
      return crc;
   endfunction

   function automatic logic [6:0] base32_symbol(logic [4:0] v);
      if (v < 5'd26) begin
         return 7'h41 + 7'(v);
      end else begin
         return 7'h32 + 7'(v - 5'd26);
      end
   endfunction

   function void shift_into_text(logic [7:0] b);
      logic [4:0] grp;
      shadow_bits  = {shadow_bits[19:0], b};
      shadow_nbits = shadow_nbits + 8;
      while (shadow_nbits >= 5) begin
         grp          = 5'(shadow_bits >> (shadow_nbits - 5));
         shadow_nbits = shadow_nbits - 5;
         text_char_q.push_back('{text_char: base32_symbol(grp), last_char: 1'b0});
      end
   endfunction

   function void clear_address();
      shadow_count = 0;
      shadow_crc   = CRC_INIT;
      shadow_bits  = '0;
      shadow_nbits = 0;
   endfunction

   function void predict_key_byte(logic [7:0] kb);
      text_char_type tail;
      // The version byte leads every address and is taken at its first key byte.
      if (shadow_count == 0) begin
         clear_address();
         shadow_crc = crc16_update(shadow_crc, shadow_version);
         shift_into_text(shadow_version);
      end
      shadow_crc = crc16_update(shadow_crc, kb);
      shift_into_text(kb);
      shadow_count = shadow_count + 1;
      if (shadow_count == KEY_BYTES) begin
         shift_into_text(shadow_crc[7:0]);
         shift_into_text(shadow_crc[15:8]);
         tail           = text_char_q.pop_back();
         tail.last_char = 1'b1;
         text_char_q.push_back(tail);
         clear_address();
      end
   endfunction

   function void log_mismatch(string msg);
      err_count = err_count + 1;
      if (err_count <= MAX_REPORTS) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
   endfunction

   always @(posedge clock) begin : monitor
      text_char_type want;
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (reset) begin
            shadow_version = VERSION_RESET;
            clear_address();
         end else begin
            if (csr_wr_en) begin
               shadow_version = csr_wr_data;
            end
            if (req_tvalid && req_tready) begin
               predict_key_byte(req_tdata);
               items_taken = items_taken + 1;
            end
            if (rsp_tvalid && rsp_tready) begin
               if (text_char_q.size() == 0) begin
                  log_mismatch($sformatf("unexpected word data=%h last=%b",
                                         rsp_tdata, rsp_tlast));
               end else begin
                  want = text_char_q.pop_front();
                  if (rsp_tdata !== {1'b0, want.text_char} || rsp_tlast !== want.last_char) begin
                     log_mismatch($sformatf("expected data=%h last=%b, got data=%h last=%b",
                                            {1'b0, want.text_char}, want.last_char,
                                            rsp_tdata, rsp_tlast));
                  end
               end
            end
         end
      end
   end

   // Sender: bursts of random length separated by random gaps, some of them empty.
   always @(negedge clock) begin : driver
      logic       next_valid;
      logic [7:0] next_data;
      next_valid = req_tvalid;
      next_data  = req_tdata;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_tvalid || req_taken) begin
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
         end else if (key_byte_q.size() > 0) begin
            next_data  = key_byte_q.pop_front();
            next_valid = 1'b1;
            if (burst_left > 1) begin
               burst_left = burst_left - 1;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
      req_tvalid <= next_valid;
      req_tdata  <= next_data;
   end

   // Receiver: switches between stall patterns, and once holds off for a long stretch.
   always @(negedge clock) begin : receiver
      logic next_ready;
      next_ready = 1'b0;
      if (!reset) begin
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
         end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = rx_mode_type'($urandom_range(0, 3));
               mode_left  = $urandom_range(8, 64);
            end else begin
               mode_left = mode_left - 1;
            end
            case (stall_mode)
               RX_OPEN: begin
                  next_ready = 1'b1;
               end
               RX_RANDOM: begin
                  next_ready = ($urandom_range(0, 3) != 0);
               end
               RX_TOGGLE: begin
                  next_ready = ~rsp_tready;
               end
               default: begin
                  next_ready = ($urandom_range(0, 7) == 0);
               end
            endcase
         end
      end
      rsp_tready <= next_ready;
   end

   task automatic push_key_byte(logic [7:0] b);
      key_byte_q.push_back(b);
      items_pushed = items_pushed + 1;
   endtask

   // Wait until every key byte is taken and every character has come back.
   task automatic drain();
      while (items_taken != items_pushed || text_char_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_version(logic [7:0] v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      int         total;
      int         round;
      int         chunk;
      logic [7:0] v;
      logic [7:0] kb;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // One full address with the reset version, starting with the byte extremes.
      push_key_byte(8'h00);
      push_key_byte(8'hFF);
      push_key_byte(8'h80);
      push_key_byte(8'h01);
      push_key_byte(8'h55);
      push_key_byte(8'hAA);
      push_key_byte(8'h7F);
      push_key_byte(8'hFE);
      for (int i = 8; i < KEY_BYTES; i++) begin
         push_key_byte(8'(i * 37));
      end
      drain();

      // The version written halfway through an address applies only to the next one.
      write_version(8'hFF);
      for (int i = 0; i < 10; i++) begin
         push_key_byte(8'(8'hC3 ^ (i * 11)));
      end
      drain();
      write_version(8'h00);
      for (int i = 10; i < KEY_BYTES; i++) begin
         push_key_byte(8'(255 - i * 5));
      end
      drain();

      total = 0;
      round = 0;
      while (total < RANDOM_ITEMS) begin
         if (round == 1) begin
            v = 8'hFF;
         end else if (round == 3) begin
            v = 8'h00;
         end else begin
            v = 8'($urandom_range(0, 255));
         end
         write_version(v);
         if (round == 2) begin
            chunk    = 48;
            hold_req = hold_req + 1;
         end else begin
            chunk = $urandom_range(4, 48);
         end
         for (int i = 0; i < chunk; i++) begin
            case ($urandom_range(0, 9))
               0: kb = 8'h00;
               1: kb = 8'hFF;
               default: kb = 8'($urandom_range(0, 255));
            endcase
            push_key_byte(kb);
         end
         total = total + chunk;
         round = round + 1;
         drain();
      end

      repeat (20) @(negedge clock);
      if (err_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
